@@ rtl/tile_slot_fifo_allocator_macros.svh @@
// Assertion macros used by the port-level checker of the tile slot allocator.
// Depends on nothing; include by bare file name.
`ifndef TILE_SLOT_FIFO_ALLOCATOR_MACROS_SVH
`define TILE_SLOT_FIFO_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSFA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define TSFA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tsfa_pkg.sv @@
// Package for the tile slot allocator: sizes, key and index types,
// controller states and the command/status structs. Depends on nothing.
package tsfa_pkg;

   localparam int SLOTS        = 64;
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W        = $clog2(SLOTS + 1);
   localparam int KEY_W        = 32;
   localparam int SLOT_FIELD_W = 6;

   typedef logic [SLOT_W-1:0]       slot_idx_type;
   typedef logic [CNT_W-1:0]        fill_type;
   typedef logic [2*KEY_W-1:0]      key_type;
   typedef logic [SLOT_FIELD_W-1:0] slot_field_type;
   typedef logic [KEY_W-1:0]        key_half_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_HIT,
      ST_ALLOC,
      ST_EVICT
   } ctrl_state_type;

   typedef struct packed {
      logic load_key;
      logic issue_rd;
      logic latch_hit;
      logic alloc;
      logic load_hit_rsp;
      logic load_miss_rsp;
   } tsfa_cmd_type;

   typedef struct packed {
      logic fill_empty;
      logic scan_last;
      logic match;
      logic rsp_free;
   } tsfa_status_type;

endpackage

@@ rtl/tsfa_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
// Depends on tsfa_pkg for field types.
interface tsfa_req_if;
   logic                  valid;
   logic                  ready;
   tsfa_pkg::key_half_type track_id;
   tsfa_pkg::key_half_type tile_position;

   modport source (output valid, output track_id, output tile_position, input ready);
   modport sink   (input valid, input track_id, input tile_position, output ready);
endinterface

interface tsfa_rsp_if;
   logic                    valid;
   logic                    ready;
   tsfa_pkg::slot_field_type slot;
   logic                    hit;
   logic                    evicted;
   tsfa_pkg::key_half_type   evicted_track_id;
   tsfa_pkg::key_half_type   evicted_position;

   modport source (output valid, output slot, output hit, output evicted,
                   output evicted_track_id, output evicted_position, input ready);
   modport sink   (input valid, input slot, input hit, input evicted,
                   input evicted_track_id, input evicted_position, output ready);
endinterface

@@ rtl/tile_slot_fifo_allocator.sv @@
// Top level of the tile slot allocator: fully associative key store with
// ring-pointer replacement. Depends on tsfa_pkg, tsfa_if, tsfa_ctrl, tsfa_datapath.
//
// Usage:
//   req_if carries one key (track_id, tile_position) per transaction.
//   rsp_if returns exactly one transaction per request: the slot holding the
//   key, hit, and on a miss into an occupied slot the evicted key.
//   Keys sit in a single-port-read key RAM that is scanned one entry per
//   cycle, lowest slot first; that scan sets the latency.
//   A hit stops the scan at the matching slot; a miss scans every valid
//   slot (none when the store is empty) before it allocates. One request is
//   in work at a time and req ready returns in the cycle after the response
//   is loaded, so a new request is taken only once the last one is done.
//   Reset clears the fill count and ring pointer, which empties the store
//   at once; no clearing pass runs and req ready is high right after reset.
//   The response is held in an output register; when rsp ready stays low
//   the block still takes the next request and finishes its scan, then
//   waits until the held response is taken before loading the new one.
module tile_slot_fifo_allocator (
   input  logic        clock,
   input  logic        reset,
   tsfa_req_if.sink    req_if,
   tsfa_rsp_if.source  rsp_if
);

   tsfa_pkg::tsfa_cmd_type    cmd;
   tsfa_pkg::tsfa_status_type status;
   logic                      req_ready;

   assign req_if.ready = req_ready;

   tsfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsfa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_track_id         (req_if.track_id),
      .req_tile_position    (req_if.tile_position),
      .rsp_ready            (rsp_if.ready),
      .rsp_valid            (rsp_if.valid),
      .rsp_slot             (rsp_if.slot),
      .rsp_hit              (rsp_if.hit),
      .rsp_evicted          (rsp_if.evicted),
      .rsp_evicted_track_id (rsp_if.evicted_track_id),
      .rsp_evicted_position (rsp_if.evicted_position)
   );

endmodule

@@ rtl/tsfa_ctrl.sv @@
// Controller state machine of the tile slot allocator: sequences the key
// scan, allocation and response load. Depends on tsfa_pkg.
module tsfa_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tsfa_pkg::tsfa_status_type status,
   output tsfa_pkg::tsfa_cmd_type    cmd
);

   tsfa_pkg::ctrl_state_type state_ff;
   tsfa_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tsfa_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.fill_empty ? tsfa_pkg::ST_ALLOC : tsfa_pkg::ST_SCAN;
            end
         end
         tsfa_pkg::ST_SCAN: begin
            priority if (status.match) begin
               state_in = tsfa_pkg::ST_HIT;
            end else if (status.scan_last) begin
               state_in = tsfa_pkg::ST_LAST;
            end
         end
         tsfa_pkg::ST_LAST: begin
            state_in = status.match ? tsfa_pkg::ST_HIT : tsfa_pkg::ST_ALLOC;
         end
         tsfa_pkg::ST_HIT: begin
            if (status.rsp_free) begin
               state_in = tsfa_pkg::ST_IDLE;
            end
         end
         tsfa_pkg::ST_ALLOC: begin
            state_in = tsfa_pkg::ST_EVICT;
         end
         tsfa_pkg::ST_EVICT: begin
            if (status.rsp_free) begin
               state_in = tsfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tsfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         tsfa_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_key = req_valid;
         end
         tsfa_pkg::ST_SCAN: begin
            // stop issuing reads once a match shows up
            cmd.latch_hit = status.match;
            cmd.issue_rd  = !status.match;
         end
         tsfa_pkg::ST_LAST: begin
            cmd.latch_hit = status.match;
         end
         tsfa_pkg::ST_HIT: begin
            cmd.load_hit_rsp = status.rsp_free;
         end
         tsfa_pkg::ST_ALLOC: begin
            cmd.alloc = 1'b1;
         end
         tsfa_pkg::ST_EVICT: begin
            cmd.load_miss_rsp = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/tsfa_datapath.sv @@
// Datapath of the tile slot allocator: key RAM, scan index, ring pointer,
// fill count and response register. Depends on tsfa_pkg.
module tsfa_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  tsfa_pkg::tsfa_cmd_type     cmd,
   output tsfa_pkg::tsfa_status_type  status,
   input  tsfa_pkg::key_half_type     req_track_id,
   input  tsfa_pkg::key_half_type     req_tile_position,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output tsfa_pkg::slot_field_type   rsp_slot,
   output logic                       rsp_hit,
   output logic                       rsp_evicted,
   output tsfa_pkg::key_half_type     rsp_evicted_track_id,
   output tsfa_pkg::key_half_type     rsp_evicted_position
);

   tsfa_pkg::key_type      key_mem [tsfa_pkg::SLOTS];
   tsfa_pkg::key_type      rd_data_ff;
   tsfa_pkg::key_type      key_ff;
   tsfa_pkg::slot_idx_type idx_ff;
   tsfa_pkg::slot_idx_type cmp_idx_ff;
   logic                   cmp_valid_ff;
   tsfa_pkg::slot_idx_type hit_slot_ff;
   tsfa_pkg::fill_type     fill_ff;
   tsfa_pkg::slot_idx_type next_ff;
   tsfa_pkg::slot_idx_type vic_slot_ff;
   logic                   vic_valid_ff;

   logic                     rsp_valid_ff;
   tsfa_pkg::slot_field_type rsp_slot_ff;
   logic                     rsp_hit_ff;
   logic                     rsp_evicted_ff;
   tsfa_pkg::key_half_type   rsp_ev_track_ff;
   tsfa_pkg::key_half_type   rsp_ev_pos_ff;

   tsfa_pkg::slot_idx_type mem_raddr;
   logic                   mem_re;
   logic                   full;

   assign full      = (fill_ff == tsfa_pkg::fill_type'(tsfa_pkg::SLOTS));
   assign mem_re    = cmd.issue_rd | cmd.alloc;
   assign mem_raddr = cmd.alloc ? next_ff : idx_ff;

   // read-before-write: an allocation returns the old key of the victim slot
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         key_mem[next_ff] <= key_ff;
      end
      if (mem_re) begin
         rd_data_ff <= key_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= {req_track_id, req_tile_position};
         idx_ff <= '0;
      end else if (cmd.issue_rd) begin
         idx_ff <= idx_ff + tsfa_pkg::slot_idx_type'(1);
      end
      cmp_idx_ff <= idx_ff;
      if (cmd.latch_hit) begin
         hit_slot_ff <= cmp_idx_ff;
      end
      if (cmd.alloc) begin
         vic_slot_ff  <= next_ff;
         vic_valid_ff <= full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
         fill_ff      <= '0;
         next_ff      <= '0;
      end else begin
         cmp_valid_ff <= cmd.issue_rd;
         if (cmd.alloc) begin
            next_ff <= (next_ff == tsfa_pkg::slot_idx_type'(tsfa_pkg::SLOTS - 1)) ?
                       '0 : next_ff + tsfa_pkg::slot_idx_type'(1);
            if (!full) begin
               fill_ff <= fill_ff + tsfa_pkg::fill_type'(1);
            end
         end
      end
   end

   // response register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_hit_rsp || cmd.load_miss_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_hit_rsp) begin
         rsp_slot_ff     <= tsfa_pkg::SLOT_FIELD_W'(hit_slot_ff);
         rsp_hit_ff      <= 1'b1;
         rsp_evicted_ff  <= 1'b0;
         rsp_ev_track_ff <= '0;
         rsp_ev_pos_ff   <= '0;
      end else if (cmd.load_miss_rsp) begin
         rsp_slot_ff     <= tsfa_pkg::SLOT_FIELD_W'(vic_slot_ff);
         rsp_hit_ff      <= 1'b0;
         rsp_evicted_ff  <= vic_valid_ff;
         rsp_ev_track_ff <= vic_valid_ff ? rd_data_ff[2*tsfa_pkg::KEY_W-1:tsfa_pkg::KEY_W] : '0;
         rsp_ev_pos_ff   <= vic_valid_ff ? rd_data_ff[tsfa_pkg::KEY_W-1:0] : '0;
      end
   end

   always_comb begin
      status.fill_empty = (fill_ff == '0);
      status.scan_last  = ((tsfa_pkg::fill_type'(idx_ff) + tsfa_pkg::fill_type'(1)) == fill_ff);
      status.match      = cmp_valid_ff && (rd_data_ff == key_ff);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_slot             = rsp_slot_ff;
   assign rsp_hit              = rsp_hit_ff;
   assign rsp_evicted          = rsp_evicted_ff;
   assign rsp_evicted_track_id = rsp_ev_track_ff;
   assign rsp_evicted_position = rsp_ev_pos_ff;

endmodule

@@ rtl/tsfa_checker.sv @@
// Port-level checker for the tile slot allocator, bound to the top level.
// Depends on tsfa_pkg and the assertion macro header.
`include "tile_slot_fifo_allocator_macros.svh"

module tsfa_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input tsfa_pkg::slot_field_type rsp_slot,
   input logic                     rsp_hit,
   input logic                     rsp_evicted,
   input tsfa_pkg::key_half_type   rsp_evicted_track_id,
   input tsfa_pkg::key_half_type   rsp_evicted_position
);

   `TSFA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_slot) && $stable(rsp_hit) && $stable(rsp_evicted) && $stable(rsp_evicted_track_id) && $stable(rsp_evicted_position), "stalled response changed")
   `TSFA_ASSERT_IMP(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted, "hit reported an eviction")
   `TSFA_ASSERT_IMP(a_evict_zero, clock, reset, rsp_valid && !rsp_evicted, (rsp_evicted_track_id == '0) && (rsp_evicted_position == '0), "evicted key not zero without eviction")
   `TSFA_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "request taken while previous one in work")

endmodule

bind tile_slot_fifo_allocator tsfa_checker u_tsfa_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_if.valid),
   .req_ready            (req_if.ready),
   .rsp_valid            (rsp_if.valid),
   .rsp_ready            (rsp_if.ready),
   .rsp_slot             (rsp_if.slot),
   .rsp_hit              (rsp_if.hit),
   .rsp_evicted          (rsp_if.evicted),
   .rsp_evicted_track_id (rsp_if.evicted_track_id),
   .rsp_evicted_position (rsp_if.evicted_position)
);

@@ tb/tile_slot_fifo_allocator_checker.sv @@
`timescale 1ns / 1ps
// Checker for the tile slot allocator. It mirrors the slot store and the ring pointer,
// predicts one response per request and compares it with the block's output.
// Depends on tsfa_pkg.
module tile_slot_fifo_allocator_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  tsfa_pkg::key_half_type   req_track_id,
   input  tsfa_pkg::key_half_type   req_tile_position,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  tsfa_pkg::slot_field_type rsp_slot,
   input  logic                     rsp_hit,
   input  logic                     rsp_evicted,
   input  tsfa_pkg::key_half_type   rsp_evicted_track_id,
   input  tsfa_pkg::key_half_type   rsp_evicted_position,
   output int                       mismatch_count,
   output int                       pending_count,
   output int                       checked_count,
   output int                       hit_count,
   output int                       eviction_count
);

   localparam int NUM_SLOTS   = tsfa_pkg::SLOTS;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      tsfa_pkg::slot_field_type slot;
      logic                     hit;
      logic                     evicted;
      tsfa_pkg::key_half_type   evicted_track_id;
      tsfa_pkg::key_half_type   evicted_position;
   } slot_grant_type;

   // mirror of the store; key entries are only read where the valid bit is set
   tsfa_pkg::key_half_type stored_track[NUM_SLOTS];
   tsfa_pkg::key_half_type stored_position[NUM_SLOTS];
   logic                   stored_valid[NUM_SLOTS];
   int                     ring_ptr;

   slot_grant_type         awaited_grants[$];
   int                     mismatches;
   int                     checked;
   int                     hits;
   int                     evictions;

   function automatic slot_grant_type grant_slot(input tsfa_pkg::key_half_type trk,
                                                 input tsfa_pkg::key_half_type pos);
      slot_grant_type g;
      int             found;
      g     = '0;
      found = -1;
      // scan downward so the lowest matching slot wins
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (stored_valid[i] && stored_track[i] == trk && stored_position[i] == pos)
            found = i;
      end
      if (found >= 0) begin
         g.slot = tsfa_pkg::slot_field_type'(found);
         g.hit  = 1'b1;
      end else begin
         if (stored_valid[ring_ptr]) begin
            g.evicted          = 1'b1;
            g.evicted_track_id = stored_track[ring_ptr];
            g.evicted_position = stored_position[ring_ptr];
         end
         stored_track[ring_ptr]    = trk;
         stored_position[ring_ptr] = pos;
         stored_valid[ring_ptr]    = 1'b1;
         g.slot   = tsfa_pkg::slot_field_type'(ring_ptr);
         ring_ptr = (ring_ptr + 1) % NUM_SLOTS;
      end
      return g;
   endfunction

   initial begin
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      evictions  = 0;
      ring_ptr   = 0;
      for (int i = 0; i < NUM_SLOTS; i++)
         stored_valid[i] = 1'b0;
   end

   always @(posedge clock) begin
      slot_grant_type want;
      slot_grant_type got;
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++)
            stored_valid[i] = 1'b0;
         ring_ptr = 0;
         awaited_grants.delete();
      end else begin
         // check the response first so a response in the same cycle as its
         // own request counts as unexpected
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_slot, rsp_hit, rsp_evicted, rsp_evicted_track_id,
                    rsp_evicted_position};
            if (awaited_grants.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: unexpected response slot=%0d hit=%0b evicted=%0b",
                           $realtime, got.slot, got.hit, got.evicted);
            end else begin
               want = awaited_grants.pop_front();
               checked++;
               if (got.hit) hits++;
               if (got.evicted) evictions++;
               if (got.slot !== want.slot || got.hit !== want.hit ||
                   got.evicted !== want.evicted ||
                   got.evicted_track_id !== want.evicted_track_id ||
                   got.evicted_position !== want.evicted_position) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("%0t: response %0d differs", $realtime, checked);
                     $display("   expected slot=%0d hit=%0b evicted=%0b key=%h/%h",
                              want.slot, want.hit, want.evicted,
                              want.evicted_track_id, want.evicted_position);
                     $display("   actual   slot=%0d hit=%0b evicted=%0b key=%h/%h",
                              got.slot, got.hit, got.evicted,
                              got.evicted_track_id, got.evicted_position);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            awaited_grants.push_back(grant_slot(req_track_id, req_tile_position));
      end
      mismatch_count <= mismatches;
      pending_count  <= awaited_grants.size();
      checked_count  <= checked;
      hit_count      <= hits;
      eviction_count <= evictions;
   end

endmodule

@@ tb/tile_slot_fifo_allocator_tb.sv @@
`timescale 1ns / 1ps
// Top of the tile slot allocator testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on tsfa_pkg, tsfa_if, the block
// and tile_slot_fifo_allocator_checker.
module tile_slot_fifo_allocator_tb;

   localparam int RANDOM_ITEMS   = 750;
   localparam int QUIET_FIRST    = 300;
   localparam int QUIET_LAST     = 449;
   localparam int POOL_SIZE      = 128;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int IDLE_PERCENT   = 22;

   logic clock;
   logic reset;
   logic quiet;
   int   sent_count;
   int   mismatch_count;
   int   pending_count;
   int   checked_count;
   int   hit_count;
   int   eviction_count;

   tsfa_pkg::key_half_type pool_track[POOL_SIZE];
   tsfa_pkg::key_half_type pool_position[POOL_SIZE];

   tsfa_req_if req_chan ();
   tsfa_rsp_if rsp_chan ();

   tile_slot_fifo_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   tile_slot_fifo_allocator_checker alloc_check (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_chan.valid),
      .req_ready            (req_chan.ready),
      .req_track_id         (req_chan.track_id),
      .req_tile_position    (req_chan.tile_position),
      .rsp_valid            (rsp_chan.valid),
      .rsp_ready            (rsp_chan.ready),
      .rsp_slot             (rsp_chan.slot),
      .rsp_hit              (rsp_chan.hit),
      .rsp_evicted          (rsp_chan.evicted),
      .rsp_evicted_track_id (rsp_chan.evicted_track_id),
      .rsp_evicted_position (rsp_chan.evicted_position),
      .mismatch_count       (mismatch_count),
      .pending_count        (pending_count),
      .checked_count        (checked_count),
      .hit_count            (hit_count),
      .eviction_count       (eviction_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // response back-pressure
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // end the run when no transaction moves for too long
   initial begin
      int stalled;
      stalled = 0;
      while (stalled < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            stalled = 0;
         else
            stalled++;
      end
      $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, pending_count);
      $display("Mismatches found");
      $finish;
   end

   // offer one key and hold it until the block takes it
   task automatic send_key(input tsfa_pkg::key_half_type trk,
                           input tsfa_pkg::key_half_type pos);
      while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.track_id      <= trk;
      req_chan.tile_position <= pos;
      do
         @(posedge clock);
      while (!req_chan.ready);
      sent_count++;
   endtask

   initial begin
      tsfa_pkg::key_half_type trk;
      tsfa_pkg::key_half_type pos;
      tsfa_pkg::key_half_type shared_tracks[4];
      int                     span;
      int                     pick;
      int                     roll;

      sent_count             = 0;
      reset                  <= 1'b1;
      quiet                  <= 1'b0;
      req_chan.valid         <= 1'b0;
      req_chan.track_id      <= '0;
      req_chan.tile_position <= '0;

      // most pool keys share a few track ids, like tiles of the same tracks
      for (int i = 0; i < 4; i++)
         shared_tracks[i] = $urandom;
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_track[i]    = ($urandom_range(0, 3) != 0) ? shared_tracks[$urandom_range(0, 3)]
                                                        : $urandom;
         pool_position[i] = ($urandom_range(0, 1) != 0) ? i : $urandom;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, miss into empty slots, hits, near matches
      send_key(32'h0000_0000, 32'h0000_0000);
      send_key(32'h0000_0000, 32'h0000_0000);
      send_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_key(32'h0000_0000, 32'hFFFF_FFFF);
      send_key(32'hFFFF_FFFF, 32'h0000_0000);
      send_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_key(32'h0000_0000, 32'h0000_0001);
      send_key(32'h0000_0001, 32'h0000_0000);
      send_key(32'hAAAA_AAAA, 32'h5555_5555);
      send_key(32'h5555_5555, 32'hAAAA_AAAA);
      send_key(32'h0000_0000, 32'hFFFF_FFFF);
      send_key(32'h8000_0000, 32'h0000_0001);
      send_key(32'h8000_0000, 32'h8000_0001);
      send_key(32'h0000_0000, 32'h0000_0000);
      send_key(32'h7FFF_FFFF, 32'hFFFF_FFFE);
      send_key(32'hAAAA_AAAA, 32'h5555_5555);
      send_key(32'h0000_0001, 32'h0000_0000);

      // random: a working set that first fits the store, then overflows it
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet <= (n >= QUIET_FIRST && n <= QUIET_LAST);
         span  = (n < 250) ? 40 : (n < 500) ? 96 : POOL_SIZE;
         pick  = $urandom_range(0, span - 1);
         roll  = $urandom_range(0, 99);
         if (roll < 65) begin
            trk = pool_track[pick];
            pos = pool_position[pick];
         end else if (roll < 80) begin
            // near match: one bit off in either half of the key
            trk = pool_track[pick];
            pos = pool_position[pick];
            if ($urandom_range(0, 1) != 0)
               trk = trk ^ (32'h1 << $urandom_range(0, 31));
            else
               pos = pos ^ (32'h1 << $urandom_range(0, 31));
         end else begin
            trk = $urandom;
            pos = $urandom;
         end
         send_key(trk, pos);
      end
      req_chan.valid <= 1'b0;
      quiet          <= 1'b0;

      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d requests; %0d responses checked with %0d hits and %0d evictions",
               sent_count, checked_count, hit_count, eviction_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
